[hw/rtl/frwl_pkg.sv]
// Package for the fair readers-writer lock manager.
// Holds the sizes, request and status codes, beat structs and state type.
// No dependencies.
`default_nettype none

package frwl_pkg;

  // Number of requesters sharing the lock; the wait queue holds one fewer.
  localparam int unsigned REQUESTERS = 64;
  localparam int unsigned PTR_W      = $clog2(REQUESTERS);
  localparam int unsigned CNT_W      = $clog2(REQUESTERS);

  localparam int unsigned ID_W    = 6;
  localparam int unsigned ENTRY_W = ID_W + 1;
  localparam int unsigned RCNT_W  = 7;

  localparam logic [RCNT_W-1:0] READER_MAX = {RCNT_W{1'b1}};

  typedef enum logic [1:0] {
    REQ_START_READ  = 2'd0,
    REQ_END_READ    = 2'd1,
    REQ_START_WRITE = 2'd2,
    REQ_END_WRITE   = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    ST_GRANT    = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_RELEASED = 3'd2,
    ST_ENDOK    = 3'd3,
    ST_ERROR    = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE    = 1'b0,
    S_RELEASE = 1'b1
  } state_e;

  typedef struct packed {
    req_type_e         req_type;
    logic [ID_W-1:0]   requester_id;
  } lock_req_t;

  typedef struct packed {
    status_e           status;
    logic [ID_W-1:0]   who;
    logic              as_writer;
    logic [RCNT_W-1:0] reader_count;
    logic              writer_holds;
    logic              last;
  } lock_res_t;

endpackage

`default_nettype wire

[hw/rtl/frwl_ram.sv]
// Generic synchronous RAM: one write port and two registered read ports.
// No dependencies.
`default_nettype none

module frwl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output      logic [WIDTH-1:0]         rdata_a_o,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output      logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

[hw/rtl/fifo_readers_writer_lock.sv]
// Top level of the fair readers-writer lock manager.
// Depends on frwl_pkg and instantiates frwl_ram for the wait queue.
`default_nettype none

// A request beat is taken at a rising edge where start_i is high and busy_o
// is low. Its first result (granted, queued, end accepted or protocol error)
// appears on res_o in the next cycle, marked by res_valid_o for exactly one
// cycle; the receiver cannot stall, so every result must be captured when
// strobed. A request that releases nobody leaves busy_o low, so such requests
// may be issued every cycle. An accepted end that releases queued waiters
// keeps busy_o high until the last is out, giving one released beat per cycle
// after its first result, in queue order; the rate is set by the wait-queue
// memory, whose registered read of the next head holds the front entry (and
// the one behind, to know when the run of readers stops) as the head moves.
// res_o.last marks the final beat caused by a request. The queue memory needs
// no clearing after reset: only entries that were written are ever released.

module fifo_readers_writer_lock
  import frwl_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire lock_req_t req_i,
  output      logic      busy_o,
  output      logic      res_valid_o,
  output      lock_res_t res_o
);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(REQUESTERS - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  state_e            state_q, state_d;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [RCNT_W-1:0] rdrs_q, rdrs_d;
  logic              wr_q, wr_d;
  logic              from_rd_q, from_rd_d;
  logic              res_vld_q, res_vld_d;
  lock_res_t         res_q, res_d;

  logic              accept;
  logic              rel_start;   // accepted end will release waiters
  logic              rel_last;    // release beat is the final one
  logic              q_full;
  logic              ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] front, behind;
  logic              front_wr;

  assign accept = start_i && (state_q == S_IDLE);
  assign q_full = (cnt_q == CNT_W'(REQUESTERS - 1));
  assign front_wr = front[ID_W];

  // The read ports always look at the head the next cycle will see, so the
  // front entry and its successor are ready as soon as a release begins.
  frwl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(REQUESTERS)
  ) u_queue (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (tail_q),
    .wdata_i  (ram_wdata),
    .raddr_a_i(head_d),
    .rdata_a_o(front),
    .raddr_b_i(ptr_inc(head_d)),
    .rdata_b_o(behind)
  );

  // Datapath and outputs: the request decision when idle, one release per
  // cycle otherwise.
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    cnt_d     = cnt_q;
    rdrs_d    = rdrs_q;
    wr_d      = wr_q;
    from_rd_d = from_rd_q;
    res_vld_d = 1'b0;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_wdata = {1'b0, req_i.requester_id};
    rel_start = 1'b0;
    rel_last  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_vld_d        = 1'b1;
          res_d.who        = req_i.requester_id;
          res_d.as_writer  = 1'b0;
          res_d.status     = ST_ERROR;
          case (req_i.req_type)
            REQ_START_READ: begin
              if (wr_q || (cnt_q != '0)) begin
                if (!q_full) begin
                  ram_we       = 1'b1;
                  tail_d       = ptr_inc(tail_q);
                  cnt_d        = cnt_q + CNT_W'(1);
                  res_d.status = ST_QUEUED;
                end
              end else if (rdrs_q != READER_MAX) begin
                rdrs_d       = rdrs_q + RCNT_W'(1);
                res_d.status = ST_GRANT;
              end
            end
            REQ_END_READ: begin
              if (rdrs_q != '0) begin
                rdrs_d       = rdrs_q - RCNT_W'(1);
                res_d.status = ST_ENDOK;
                rel_start    = (rdrs_q == RCNT_W'(1)) && (cnt_q != '0);
                from_rd_d    = 1'b1;
              end
            end
            REQ_START_WRITE: begin
              res_d.as_writer = 1'b1;
              ram_wdata       = {1'b1, req_i.requester_id};
              if (wr_q || (rdrs_q != '0)) begin
                if (!q_full) begin
                  ram_we       = 1'b1;
                  tail_d       = ptr_inc(tail_q);
                  cnt_d        = cnt_q + CNT_W'(1);
                  res_d.status = ST_QUEUED;
                end
              end else begin
                wr_d         = 1'b1;
                res_d.status = ST_GRANT;
              end
            end
            REQ_END_WRITE: begin
              res_d.as_writer = 1'b1;
              if (wr_q) begin
                wr_d         = 1'b0;
                res_d.status = ST_ENDOK;
                rel_start    = (cnt_q != '0);
                from_rd_d    = 1'b0;
              end
            end
            default: begin
              res_d.status = ST_ERROR;
            end
          endcase
          res_d.reader_count = rdrs_d;
          res_d.writer_holds = wr_d;
          res_d.last         = !rel_start;
        end
      end
      S_RELEASE: begin
        head_d = ptr_inc(head_q);
        cnt_d  = cnt_q - CNT_W'(1);
        if (front_wr) begin
          wr_d = 1'b1;
        end else if (rdrs_q != READER_MAX) begin
          rdrs_d = rdrs_q + RCNT_W'(1);
        end
        // An end of read frees one waiter; a front writer goes alone; a run
        // of readers stops at an empty queue or at a queued writer.
        rel_last = from_rd_q || front_wr || (cnt_d == '0) || behind[ID_W];
        res_vld_d          = 1'b1;
        res_d.status       = ST_RELEASED;
        res_d.who          = front[ID_W-1:0];
        res_d.as_writer    = front_wr;
        res_d.reader_count = rdrs_d;
        res_d.writer_holds = wr_d;
        res_d.last         = rel_last;
      end
      default: begin
        res_vld_d = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (rel_start) begin
          state_d = S_RELEASE;
        end
      end
      S_RELEASE: begin
        if (rel_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      cnt_q     <= '0;
      rdrs_q    <= '0;
      wr_q      <= 1'b0;
      from_rd_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      cnt_q     <= cnt_d;
      rdrs_q    <= rdrs_d;
      wr_q      <= wr_d;
      from_rd_q <= from_rd_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Result payload needs no reset; it is qualified by the strobe.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  // A result that is not the last of its request is followed at once by
  // another beat.
  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && !res_q.last) |=> res_vld_q)
    else $error("non-final result not followed by another beat");

  // Releases only ever draw from a non-empty queue.
  a_release_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RELEASE) |-> (cnt_q != '0))
    else $error("release attempted with an empty wait queue");

  // A writer and readers never hold the lock together.
  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q |-> (rdrs_q == '0))
    else $error("writer holds the lock while readers are counted");

  // A run of releases always opens with the accepted end that caused it.
  a_release_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_RELEASE) && ($past(state_q) == S_IDLE))
      |-> (res_vld_q && (res_q.status == ST_ENDOK) && !res_q.last))
    else $error("release run not preceded by an accepted end");

endmodule

`default_nettype wire

[dv/tb_fifo_readers_writer_lock.sv]
// Self-checking testbench for the fair readers-writer lock manager.
// Depends on frwl_pkg and fifo_readers_writer_lock; a built-in lock predictor
// checks every result beat: directed table, random mix, full queue, reader flood.
`timescale 1ns / 100ps

module tb_fifo_readers_writer_lock
  import frwl_pkg::*;
();

  localparam int RANDOM_ITEMS  = 70;
  localparam int IDLE_PERCENT  = 17;
  // Longest release burst is one beat per queue entry, so this covers it.
  localparam int SETTLE_CYCLES = 2 * REQUESTERS + 16;

  // One row of the opening table. Where pinned is set, the first result beat
  // of the request is typed in by hand and replaces the predicted one.
  typedef struct packed {
    lock_req_t req;
    logic      pinned;
    lock_res_t first;
  } step_t;

  localparam step_t OPENING_STEPS [0:20] = '{
    // Ends with nothing held are protocol errors straight out of reset.
    '{'{REQ_END_READ,    6'd0},  1'b1, '{ST_ERROR, 6'd0,  1'b0, 7'd0, 1'b0, 1'b1}},
    '{'{REQ_END_WRITE,   6'd63}, 1'b1, '{ST_ERROR, 6'd63, 1'b1, 7'd0, 1'b0, 1'b1}},
    '{'{REQ_START_READ,  6'd0},  1'b1, '{ST_GRANT, 6'd0,  1'b0, 7'd1, 1'b0, 1'b1}},
    '{'{REQ_START_READ,  6'd63}, 1'b1, '{ST_GRANT, 6'd63, 1'b0, 7'd2, 1'b0, 1'b1}},
    '{'{REQ_START_WRITE, 6'd5},  1'b1, '{ST_QUEUED, 6'd5, 1'b1, 7'd2, 1'b0, 1'b1}},
    // A reader has to queue behind the waiting writer, for fairness.
    '{'{REQ_START_READ,  6'd10}, 1'b0, '0},
    '{'{REQ_END_WRITE,   6'd7},  1'b1, '{ST_ERROR, 6'd7,  1'b1, 7'd2, 1'b0, 1'b1}},
    '{'{REQ_END_READ,    6'd0},  1'b0, '0},
    // The last reader leaving hands the lock to the queued writer.
    '{'{REQ_END_READ,    6'd63}, 1'b0, '0},
    '{'{REQ_START_READ,  6'd42}, 1'b0, '0},
    '{'{REQ_START_WRITE, 6'd21}, 1'b0, '0},
    '{'{REQ_START_READ,  6'd1},  1'b0, '0},
    // The writer leaving releases readers up to the next queued writer.
    '{'{REQ_END_WRITE,   6'd5},  1'b0, '0},
    '{'{REQ_END_READ,    6'd10}, 1'b0, '0},
    '{'{REQ_END_READ,    6'd42}, 1'b0, '0},
    '{'{REQ_END_WRITE,   6'd21}, 1'b0, '0},
    '{'{REQ_END_READ,    6'd1},  1'b0, '0},
    '{'{REQ_START_WRITE, 6'd63}, 1'b1, '{ST_GRANT, 6'd63, 1'b1, 7'd0, 1'b1, 1'b1}},
    '{'{REQ_START_WRITE, 6'd0},  1'b0, '0},
    // A writer leaving with a writer at the front releases that writer only.
    '{'{REQ_END_WRITE,   6'd63}, 1'b0, '0},
    '{'{REQ_END_WRITE,   6'd0},  1'b1, '{ST_ENDOK, 6'd0,  1'b1, 7'd0, 1'b0, 1'b1}}
  };

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  lock_req_t req_i;
  logic      busy_o;
  logic      res_valid_o;
  lock_res_t res_o;

  fifo_readers_writer_lock u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // Lock state as the predictor sees it after every accepted request beat.
  logic [ENTRY_W-1:0] waiters [REQUESTERS];
  int                 wq_head    = 0;
  int                 wq_tail    = 0;
  int                 wq_count   = 0;
  int                 readers    = 0;
  logic               writer_in  = 1'b0;

  // Result beats of the request being predicted, then the beats still owed.
  lock_res_t          burst [REQUESTERS];
  int                 burst_len;
  lock_res_t          expected_beats [$];

  bit                 idling_on      = 1'b1;
  int                 mismatches     = 0;
  int                 requests_sent  = 0;
  int                 beats_seen     = 0;
  int                 deepest_queue  = 0;
  int                 peak_readers   = 0;
  int                 longest_burst  = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop, far beyond the slowest legal run of this stimulus.
  initial begin
    #5ms;
    $display("Timed out with %0d result beats still owed.", expected_beats.size());
    $display("simulation failed");
    $finish;
  end

  // Records one result beat against the lock state as it stands now.
  function automatic void note(status_e st, logic [ID_W-1:0] id, logic wr);
    burst[burst_len] = '{status: st, who: id, as_writer: wr,
                         reader_count: RCNT_W'(readers), writer_holds: writer_in,
                         last: 1'b0};
    burst_len++;
  endfunction

  // Appends a waiter; fails when the queue already holds all but one requester.
  function automatic bit park(logic [ID_W-1:0] id, logic wr);
    if (wq_count >= REQUESTERS - 1) return 1'b0;
    waiters[wq_tail] = {wr, id};
    wq_tail = (wq_tail + 1) % REQUESTERS;
    wq_count++;
    if (wq_count > deepest_queue) deepest_queue = wq_count;
    return 1'b1;
  endfunction

  // Hands the lock to the front waiter in the role it waited for.
  function automatic void release_front();
    logic [ENTRY_W-1:0] entry;
    entry = waiters[wq_head];
    wq_head = (wq_head + 1) % REQUESTERS;
    wq_count--;
    if (entry[ID_W]) writer_in = 1'b1;
    else if (readers < READER_MAX) readers++;
    note(ST_RELEASED, entry[ID_W-1:0], entry[ID_W]);
  endfunction

  // Works out every result beat caused by one request and updates the state.
  function automatic void predict_lock(lock_req_t r);
    logic [ID_W-1:0] id;
    id = r.requester_id;
    burst_len = 0;
    case (r.req_type)
      REQ_START_READ: begin
        if (writer_in || wq_count != 0) begin
          if (park(id, 1'b0)) note(ST_QUEUED, id, 1'b0);
          else note(ST_ERROR, id, 1'b0);
        end else if (readers >= READER_MAX) begin
          note(ST_ERROR, id, 1'b0);
        end else begin
          readers++;
          note(ST_GRANT, id, 1'b0);
        end
      end
      REQ_END_READ: begin
        if (readers == 0) begin
          note(ST_ERROR, id, 1'b0);
        end else begin
          readers--;
          note(ST_ENDOK, id, 1'b0);
          if (readers == 0 && wq_count != 0) release_front();
        end
      end
      REQ_START_WRITE: begin
        if (writer_in || readers != 0) begin
          if (park(id, 1'b1)) note(ST_QUEUED, id, 1'b1);
          else note(ST_ERROR, id, 1'b1);
        end else begin
          writer_in = 1'b1;
          note(ST_GRANT, id, 1'b1);
        end
      end
      default: begin
        if (!writer_in) begin
          note(ST_ERROR, id, 1'b1);
        end else begin
          writer_in = 1'b0;
          note(ST_ENDOK, id, 1'b1);
          if (wq_count != 0) begin
            if (waiters[wq_head][ID_W]) begin
              release_front();
            end else begin
              while (wq_count != 0 && !waiters[wq_head][ID_W] && burst_len < REQUESTERS)
                release_front();
            end
          end
        end
      end
    endcase
    burst[burst_len-1].last = 1'b1;
    if (readers > peak_readers) peak_readers = readers;
    if (burst_len > longest_burst) longest_burst = burst_len;
  endfunction

  function automatic logic [ID_W-1:0] any_id();
    return ID_W'($urandom_range(REQUESTERS - 1));
  endfunction

  function automatic lock_req_t ask(req_type_e t, logic [ID_W-1:0] id);
    return '{req_type: t, requester_id: id};
  endfunction

  // Offers one request beat, with random idle cycles ahead of it, and waits
  // until the block takes it. Returns in the time step of the accepting edge,
  // so the next call may keep start_i high without a dip.
  task automatic issue(input lock_req_t r, input logic pinned = 1'b0,
                       input lock_res_t first = '0);
    while (idling_on && $urandom_range(99) < IDLE_PERCENT) begin
      start_i <= 1'b0;
      req_i   <= lock_req_t'(8'($urandom));
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_lock(r);
    if (pinned) burst[0] = first;
    for (int k = 0; k < burst_len; k++) expected_beats.push_back(burst[k]);
    requests_sent++;
  endtask

  // Ends whatever is held until the lock is free; the queue empties with it,
  // since waiters can only exist while somebody holds the lock.
  task automatic drain_lock();
    while (writer_in || readers != 0) begin
      if (writer_in) issue(ask(REQ_END_WRITE, any_id()));
      else issue(ask(REQ_END_READ, any_id()));
    end
  endtask

  // Takes the lock as writer, then offers one more start than the queue can
  // hold, so the last one is refused; the closing end_write then releases
  // as many waiters as one request can release, and they keep the lock.
  task automatic fill_queue(input int reader_pct);
    req_type_e t;
    drain_lock();
    issue(ask(REQ_START_WRITE, any_id()));
    repeat (REQUESTERS) begin
      if ($urandom_range(99) < reader_pct) t = REQ_START_READ;
      else t = REQ_START_WRITE;
      issue(ask(t, any_id()));
    end
    issue(ask(REQ_END_WRITE, any_id()));
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Every strobed result beat must be captured in its one cycle; it is matched
  // against the oldest beat still owed, field by field.
  always @(posedge clk_i) begin
    lock_res_t want;
    if (rst_ni && res_valid_o) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing owed: status %0d, who %0d",
               res_o.status, res_o.who);
        mismatches++;
      end else begin
        want = expected_beats.pop_front();
        check_field("status",       8'(want.status),       8'(res_o.status));
        check_field("who",          8'(want.who),          8'(res_o.who));
        check_field("as_writer",    8'(want.as_writer),    8'(res_o.as_writer));
        check_field("reader_count", 8'(want.reader_count), 8'(res_o.reader_count));
        check_field("writer_holds", 8'(want.writer_holds), 8'(res_o.writer_holds));
        check_field("last",         8'(want.last),         8'(res_o.last));
      end
    end
  end

  initial begin
    req_type_e t;
    int        pick;

    rst_ni  = 1'b0;
    start_i = 1'b0;
    req_i   = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening: errors from reset, grants, queueing and each kind of
    // release, with the ids at both ends of their range.
    foreach (OPENING_STEPS[k])
      issue(OPENING_STEPS[k].req, OPENING_STEPS[k].pinned, OPENING_STEPS[k].first);

    // Random mix. Requests are weighted by who holds the lock, so most ends
    // are legal and queues build up behind writers; the rest is error noise.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idling_on = !(i >= 20 && i < 50);
      pick = $urandom_range(99);
      if (writer_in) begin
        if (pick < 30) t = REQ_END_WRITE;
        else if (pick < 65) t = REQ_START_READ;
        else if (pick < 90) t = REQ_START_WRITE;
        else t = REQ_END_READ;
      end else if (readers != 0) begin
        if (pick < 35) t = REQ_END_READ;
        else if (pick < 65) t = REQ_START_READ;
        else if (pick < 90) t = REQ_START_WRITE;
        else t = REQ_END_WRITE;
      end else begin
        if (pick < 40) t = REQ_START_READ;
        else if (pick < 80) t = REQ_START_WRITE;
        else if (pick < 90) t = REQ_END_READ;
        else t = REQ_END_WRITE;
      end
      issue(ask(t, any_id()));
    end
    idling_on = 1'b1;

    // Full queue behind a writer, then the longest release burst.
    fill_queue(100);

    // Reader flood on top of the released readers: grants up to the counter
    // limit, then one refusal.
    while (readers < READER_MAX) issue(ask(REQ_START_READ, any_id()));
    issue(ask(REQ_START_READ, any_id()));
    start_i <= 1'b0;

    // Let every owed beat arrive, then watch a while longer for strays.
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d lock requests and %0d result beats; deepest wait queue %0d,",
             requests_sent, beats_seen, deepest_queue);
    $display("peak reader count %0d, longest burst from a single request %0d beats.",
             peak_readers, longest_burst);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
